@@ sv/sds_pkg.sv @@
// Shared types and constants for the SCAN disk scheduler.
// No dependencies; used by sds_ram and scan_disk_schedule_unit.
package sds_pkg;

    localparam int CYL_W = 16;

    typedef logic [CYL_W-1:0] cyl_t;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_INS_RD  = 9'b000000010,
        ST_INS_CMP = 9'b000000100,
        ST_SPL_RD  = 9'b000001000,
        ST_SPL_CMP = 9'b000010000,
        ST_LO_RD   = 9'b000100000,
        ST_LO_OUT  = 9'b001000000,
        ST_HI_RD   = 9'b010000000,
        ST_HI_OUT  = 9'b100000000
    } state_t;

endpackage

@@ sv/sds_ram.sv @@
// Request store: one write port, one read port, registered read data.
// Depends on sds_pkg for the cylinder type.
module sds_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  sds_pkg::cyl_t     wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output sds_pkg::cyl_t     rdata
);

    sds_pkg::cyl_t mem [DEPTH];
    sds_pkg::cyl_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/scan_disk_schedule_unit.sv @@
// SCAN (elevator toward cylinder zero) disk scheduler, top level.
// Depends on sds_pkg and sds_ram.
//
// Requests enter one per accepted item (start high while busy is low) and are
// insertion-sorted into the request store as they arrive. A read-compare-write
// loop shifts each stored entry larger than the request up one place; the
// request is then written above the first smaller or equal entry, or at the
// bottom of the store. Busy stays high for the whole loop. The item marked
// batch_end then starts a split scan that counts the requests at or below
// head_position. After that come count+1 results, the last flagged by
// order_end. The zero end follows the last lower result in the very next
// cycle. Results appear on service_cylinder for one cycle with result_valid
// high; the receiver cannot stall them. Requests beyond MAX_REQUESTS are
// dropped, but their batch_end still closes the batch. head_position is
// written through cfg_valid/cfg_data (cfg_ready is always high); the user
// must write it only while busy is low, as the block does not enforce this.
// No clearing pass after reset.
module scan_disk_schedule_unit #(
    parameter int MAX_REQUESTS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [15:0]          request_cylinder,
    input  logic                 batch_end,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data,
    output logic                 result_valid,
    output logic [15:0]          service_cylinder,
    output logic                 order_end
);

    localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
    localparam int ADDR_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_REQUESTS);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    sds_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] split_reg, split_next;
    logic             last_reg, last_next;
    sds_pkg::cyl_t    key_reg, key_next;
    sds_pkg::cyl_t    head_reg;
    logic             result_valid_reg, result_valid_next;
    logic             order_end_reg, order_end_next;
    sds_pkg::cyl_t    service_reg, service_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    sds_pkg::cyl_t     mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    sds_pkg::cyl_t     rd_data;
    logic [CNT_W-1:0]  pos_dec;
    logic [CNT_W-1:0]  pos_inc;

    assign pos_dec = pos_reg - ONE;
    assign pos_inc = pos_reg + ONE;

    sds_ram #(
        .DEPTH  (MAX_REQUESTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        pos_next          = pos_reg;
        split_next        = split_reg;
        last_next         = last_reg;
        key_next          = key_reg;
        result_valid_next = 1'b0;
        order_end_next    = 1'b0;
        service_next      = service_reg;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = '0;
        mem_re            = 1'b0;
        mem_raddr         = '0;

        unique case (state_reg)
            sds_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    last_next = batch_end;
                    if (count_reg != FULL)
                    begin
                        key_next   = request_cylinder;
                        pos_next   = count_reg;
                        state_next = sds_pkg::ST_INS_RD;
                    end
                    else if (batch_end)
                    begin
                        split_next = '0;
                        state_next = sds_pkg::ST_SPL_RD;
                    end
                end
            end
            sds_pkg::ST_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = key_reg;
                    count_next = count_reg + ONE;
                    split_next = '0;
                    state_next = last_reg ? sds_pkg::ST_SPL_RD : sds_pkg::ST_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = pos_dec[ADDR_W-1:0];
                    state_next = sds_pkg::ST_INS_CMP;
                end
            end
            sds_pkg::ST_INS_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[ADDR_W-1:0];
                if (rd_data > key_reg)
                begin
                    mem_wdata  = rd_data;
                    pos_next   = pos_dec;
                    state_next = sds_pkg::ST_INS_RD;
                end
                else
                begin
                    mem_wdata  = key_reg;
                    count_next = count_reg + ONE;
                    split_next = '0;
                    state_next = last_reg ? sds_pkg::ST_SPL_RD : sds_pkg::ST_IDLE;
                end
            end
            sds_pkg::ST_SPL_RD:
            begin
                if (split_reg == count_reg)
                begin
                    pos_next   = split_reg;
                    state_next = sds_pkg::ST_LO_RD;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = split_reg[ADDR_W-1:0];
                    state_next = sds_pkg::ST_SPL_CMP;
                end
            end
            sds_pkg::ST_SPL_CMP:
            begin
                if (rd_data <= head_reg)
                begin
                    split_next = split_reg + ONE;
                    state_next = sds_pkg::ST_SPL_RD;
                end
                else
                begin
                    pos_next   = split_reg;
                    state_next = sds_pkg::ST_LO_RD;
                end
            end
            sds_pkg::ST_LO_RD:
            begin
                if (pos_reg == '0)
                begin
                    result_valid_next = 1'b1;
                    service_next      = '0;
                    order_end_next    = (split_reg == count_reg);
                    pos_next          = split_reg;
                    state_next        = sds_pkg::ST_HI_RD;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = pos_dec[ADDR_W-1:0];
                    state_next = sds_pkg::ST_LO_OUT;
                end
            end
            sds_pkg::ST_LO_OUT:
            begin
                result_valid_next = 1'b1;
                service_next      = rd_data;
                pos_next          = pos_dec;
                state_next        = sds_pkg::ST_LO_RD;
            end
            sds_pkg::ST_HI_RD:
            begin
                if (pos_reg == count_reg)
                begin
                    count_next = '0;
                    split_next = '0;
                    state_next = sds_pkg::ST_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = pos_reg[ADDR_W-1:0];
                    state_next = sds_pkg::ST_HI_OUT;
                end
            end
            sds_pkg::ST_HI_OUT:
            begin
                result_valid_next = 1'b1;
                service_next      = rd_data;
                order_end_next    = (pos_inc == count_reg);
                pos_next          = pos_inc;
                state_next        = sds_pkg::ST_HI_RD;
            end
            default:
            begin
                state_next = sds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sds_pkg::ST_IDLE;
            count_reg        <= '0;
            pos_reg          <= '0;
            split_reg        <= '0;
            last_reg         <= 1'b0;
            head_reg         <= '0;
            result_valid_reg <= 1'b0;
            order_end_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            pos_reg          <= pos_next;
            split_reg        <= split_next;
            last_reg         <= last_next;
            result_valid_reg <= result_valid_next;
            order_end_reg    <= order_end_next;
            if (cfg_valid && cfg_ready)
            begin
                head_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        service_reg <= service_next;
    end

    assign busy             = (state_reg != sds_pkg::ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign result_valid     = result_valid_reg;
    assign service_cylinder = service_reg;
    assign order_end        = order_end_reg;

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result emitted while idle");

    a_end_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
        order_end |-> result_valid)
        else $error("order_end without result_valid");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("request count above capacity");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && count_reg == FULL && !batch_end) |=> (count_reg == FULL && !busy))
        else $error("request accepted into a full store");

    a_split_bound: assert property (@(posedge clk) disable iff (!rst_n)
        split_reg <= count_reg)
        else $error("split point beyond stored requests");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && order_end) |=> !result_valid)
        else $error("result after the end of the service order");

endmodule
